@@ rtl/core/bpc_pkg.sv @@
// Shared widths, constants and register codes for the barometric compensation core.
// No dependencies; imported by every module in rtl/core.
package bpc_pkg;

    // field widths
    localparam int RAW_W   = 24;   // raw conversion results
    localparam int CAL_W   = 16;   // calibration words
    localparam int IDX_W   = 3;    // config register index
    localparam int POUT_W  = 32;   // pressure result
    localparam int TOUT_W  = 19;   // temperature result

    // internal widths
    localparam int DT_W    = 25;   // dT, signed
    localparam int CPROD_W = 42;   // dT * calibration word
    localparam int DSQ_W   = 50;   // dT * dT
    localparam int TEMP_W  = 20;   // first-order TEMP
    localparam int T2_W    = 19;   // dT^2 / 2^31, never negative
    localparam int SQ_W    = 40;   // squared temperature deviations
    localparam int ACC_W   = 46;   // OFF, SENS and their corrections
    localparam int SPLIT_W = 23;   // low slice of SENS for the split multiply
    localparam int PROD_W  = RAW_W + ACC_W;
    localparam int DIFF_W  = 50;   // raw*SENS/2^21 - OFF

    // shift amounts of the truncating divisions
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_PRES = 21;
    localparam int SH_OUT  = 15;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_C5   = 8;

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -TEMP_W'(1500);

    // start to strobe, in clock edges
    localparam int PIPE_LAT = 10;

    typedef enum logic [IDX_W-1:0] {
        REG_SENS_BASE     = 3'd0,
        REG_OFFSET_BASE   = 3'd1,
        REG_SENS_TEMP     = 3'd2,
        REG_OFFSET_TEMP   = 3'd3,
        REG_REF_TEMP      = 3'd4,
        REG_TEMP_SLOPE    = 3'd5,
        REG_SECOND_ORDER  = 3'd6
    } t_cfg_reg;

endpackage

@@ rtl/core/bpc_press_mul.sv @@
// Two-stage split multiplier: raw pressure (unsigned) times SENS (signed, ACC_W bits).
// Depends on bpc_pkg for widths.
module bpc_press_mul import bpc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [RAW_W-1:0]         i_raw,
    input  logic signed [ACC_W-1:0]  i_sens,
    output logic                     o_valid,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam int HI_W = ACC_W - SPLIT_W;

    logic                           r_va;
    logic [RAW_W+SPLIT_W-1:0]       r_lo;
    logic signed [RAW_W+HI_W:0]     r_hi;
    logic signed [PROD_W-1:0]       n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_va    <= i_valid;
            o_valid <= r_va;
        end
    end

    // low slice unsigned, high slice carries the sign
    always_ff @(posedge i_clk) begin
        r_lo <= i_raw * i_sens[SPLIT_W-1:0];
        r_hi <= $signed({1'b0, i_raw}) * $signed(i_sens[ACC_W-1:SPLIT_W]);
    end

    assign n_prod = (PROD_W'(r_hi) <<< SPLIT_W) + PROD_W'($signed({1'b0, r_lo}));

    always_ff @(posedge i_clk) begin
        o_prod <= n_prod;
    end

endmodule

@@ rtl/core/baro_pressure_compensation_core.sv @@
// Top level of the barometric pressure/temperature compensation core.
// Depends on bpc_pkg and bpc_press_mul.
//
// Usage:
//   Item channel: drive i_raw_pressure and i_raw_temperature with i_start high;
//   the item is taken at a rising edge with i_start high and o_busy low.
//   o_busy is high only while i_rst_n is low, so one item can be taken every
//   cycle. Each item gives exactly one result: o_pressure_out (0.01 mbar,
//   wrapped to 32 bits) and o_temperature_out (0.01 degC) valid for the one
//   cycle o_done is high. Throughput is one item per cycle; the pipe has
//   ten stages: dT, three calibration products and dT*dT, first-order terms,
//   squares, second-order terms, corrected OFF/SENS, the two-stage split
//   multiply raw*SENS, the subtract of OFF and the final scaling.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0..6) and
//   i_cfg_data; o_cfg_ready is always high, index 7 is ignored. Calibration
//   is read live by the pipe, so write it only with no items in flight.
//   Reset (synchronous, active low) clears the calibration words, the
//   second-order enable and every in-flight item. The receiver cannot stall:
//   results appear on their fixed cycle and are not held.
module baro_pressure_compensation_core import bpc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    output logic                      o_done,
    output logic signed [POUT_W-1:0]  o_pressure_out,
    output logic signed [TOUT_W-1:0]  o_temperature_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data
);

    // ---------------- calibration registers ----------------
    logic [CAL_W-1:0] r_sens_base, r_offset_base, r_sens_temp, r_offset_temp;
    logic [CAL_W-1:0] r_ref_temp, r_temp_slope;
    logic             r_second_on;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_base   <= '0;
            r_offset_base <= '0;
            r_sens_temp   <= '0;
            r_offset_temp <= '0;
            r_ref_temp    <= '0;
            r_temp_slope  <= '0;
            r_second_on   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SENS_BASE:    r_sens_base   <= i_cfg_data;
                REG_OFFSET_BASE:  r_offset_base <= i_cfg_data;
                REG_SENS_TEMP:    r_sens_temp   <= i_cfg_data;
                REG_OFFSET_TEMP:  r_offset_temp <= i_cfg_data;
                REG_REF_TEMP:     r_ref_temp    <= i_cfg_data;
                REG_TEMP_SLOPE:   r_temp_slope  <= i_cfg_data;
                REG_SECOND_ORDER: r_second_on   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v9;
    logic w_v8;
    logic n_accept;

    assign n_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v9   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= n_accept;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v9   <= w_v8;
            o_done <= r_v9;
        end
    end

    // ---------------- stage 1: dT ----------------
    logic signed [DT_W-1:0] n_dt, r_s1_dt;
    logic [RAW_W-1:0]       r_s1_d1;

    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, r_ref_temp, {SH_C5{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_s1_dt <= n_dt;
        r_s1_d1 <= i_raw_pressure;
    end

    // ---------------- stage 2: calibration products ----------------
    logic signed [CPROD_W-1:0] r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [DSQ_W-1:0]   r_s2_dsq;
    logic [RAW_W-1:0]          r_s2_d1;

    always_ff @(posedge i_clk) begin
        r_s2_p6  <= r_s1_dt * $signed({1'b0, r_temp_slope});
        r_s2_p4  <= r_s1_dt * $signed({1'b0, r_offset_temp});
        r_s2_p3  <= r_s1_dt * $signed({1'b0, r_sens_temp});
        r_s2_dsq <= r_s1_dt * r_s1_dt;
        r_s2_d1  <= r_s1_d1;
    end

    // ---------------- stage 3: first-order TEMP, OFF, SENS ----------------
    // truncation toward zero: bias negatives by 2^k-1 before the arithmetic shift
    logic signed [CPROD_W-1:0] n_p6_adj, n_p4_adj, n_p3_adj;
    logic signed [DSQ_W-1:0]   n_dsq_sh;
    logic signed [TEMP_W-1:0]  r_s3_temp;
    logic signed [ACC_W-1:0]   r_s3_off, r_s3_sens;
    logic [T2_W-1:0]           r_s3_t2;
    logic [RAW_W-1:0]          r_s3_d1;

    assign n_p6_adj = r_s2_p6 + (r_s2_p6[CPROD_W-1] ?
                      CPROD_W'((64'd1 << SH_TEMP) - 64'd1) : CPROD_W'(0));
    assign n_p4_adj = r_s2_p4 + (r_s2_p4[CPROD_W-1] ?
                      CPROD_W'((64'd1 << SH_OFF) - 64'd1) : CPROD_W'(0));
    assign n_p3_adj = r_s2_p3 + (r_s2_p3[CPROD_W-1] ?
                      CPROD_W'((64'd1 << SH_SENS) - 64'd1) : CPROD_W'(0));
    assign n_dsq_sh = r_s2_dsq >>> SH_T2;

    always_ff @(posedge i_clk) begin
        r_s3_temp <= TEMP_W'(n_p6_adj >>> SH_TEMP) + TEMP_REF;
        r_s3_off  <= ACC_W'($signed({1'b0, r_offset_base, {SH_C2{1'b0}}}))
                   + ACC_W'(n_p4_adj >>> SH_OFF);
        r_s3_sens <= ACC_W'($signed({1'b0, r_sens_base, {SH_C1{1'b0}}}))
                   + ACC_W'(n_p3_adj >>> SH_SENS);
        r_s3_t2   <= n_dsq_sh[T2_W-1:0];
        r_s3_d1   <= r_s2_d1;
    end

    // ---------------- stage 4: squares, low-temp flags ----------------
    logic signed [TEMP_W-1:0] n_low, n_vlow, n_tcorr;
    logic signed [SQ_W-1:0]   r_s4_lsq, r_s4_vsq;
    logic                     r_s4_lt, r_s4_vlt;
    logic signed [TOUT_W-1:0] r_s4_tout;
    logic signed [ACC_W-1:0]  r_s4_off, r_s4_sens;
    logic [RAW_W-1:0]         r_s4_d1;
    logic                     n_lt;

    assign n_low   = r_s3_temp - TEMP_REF;
    assign n_vlow  = r_s3_temp - TEMP_VLOW;
    assign n_tcorr = r_s3_temp - $signed({1'b0, r_s3_t2});
    assign n_lt    = r_second_on && (r_s3_temp < TEMP_REF);

    always_ff @(posedge i_clk) begin
        r_s4_lsq  <= n_low * n_low;
        r_s4_vsq  <= n_vlow * n_vlow;
        r_s4_lt   <= n_lt;
        r_s4_vlt  <= r_s3_temp < TEMP_VLOW;
        r_s4_tout <= n_lt ? TOUT_W'(n_tcorr) : TOUT_W'(r_s3_temp);
        r_s4_off  <= r_s3_off;
        r_s4_sens <= r_s3_sens;
        r_s4_d1   <= r_s3_d1;
    end

    // ---------------- stage 5: OFF2, SENS2 ----------------
    // 5*lsq/2, 5*lsq/4, 7*vsq, 11*vsq/2; all terms are non-negative
    logic signed [ACC_W-1:0] n_lsq_x, n_vsq_x, n_l5, n_v7, n_v11;
    logic signed [ACC_W-1:0] n_off2, n_sens2;
    logic signed [ACC_W-1:0] r_s5_off2, r_s5_sens2, r_s5_off, r_s5_sens;
    logic                    r_s5_lt;
    logic signed [TOUT_W-1:0] r_s5_tout;
    logic [RAW_W-1:0]        r_s5_d1;

    always_comb begin
        n_lsq_x = ACC_W'(r_s4_lsq);
        n_vsq_x = ACC_W'(r_s4_vsq);
        n_l5    = (n_lsq_x <<< 2) + n_lsq_x;
        n_v7    = (n_vsq_x <<< 3) - n_vsq_x;
        n_v11   = (n_vsq_x <<< 3) + (n_vsq_x <<< 1) + n_vsq_x;
        n_off2  = n_l5 >>> 1;
        n_sens2 = n_l5 >>> 2;
        if (r_s4_vlt) begin
            n_off2  = n_off2 + n_v7;
            n_sens2 = n_sens2 + (n_v11 >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_off2  <= n_off2;
        r_s5_sens2 <= n_sens2;
        r_s5_off   <= r_s4_off;
        r_s5_sens  <= r_s4_sens;
        r_s5_lt    <= r_s4_lt;
        r_s5_tout  <= r_s4_tout;
        r_s5_d1    <= r_s4_d1;
    end

    // ---------------- stage 6: corrected OFF, SENS ----------------
    logic signed [ACC_W-1:0]  r_s6_off, r_s6_sens;
    logic signed [TOUT_W-1:0] r_s6_tout;
    logic [RAW_W-1:0]         r_s6_d1;

    always_ff @(posedge i_clk) begin
        r_s6_off  <= r_s5_lt ? r_s5_off - r_s5_off2 : r_s5_off;
        r_s6_sens <= r_s5_lt ? r_s5_sens - r_s5_sens2 : r_s5_sens;
        r_s6_tout <= r_s5_tout;
        r_s6_d1   <= r_s5_d1;
    end

    // ---------------- stages 7-8: raw pressure * SENS ----------------
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  r_s7_off, r_s8_off;
    logic signed [TOUT_W-1:0] r_s7_tout, r_s8_tout;

    bpc_press_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_raw   (r_s6_d1),
        .i_sens  (r_s6_sens),
        .o_valid (w_v8),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        r_s7_off  <= r_s6_off;
        r_s8_off  <= r_s7_off;
        r_s7_tout <= r_s6_tout;
        r_s8_tout <= r_s7_tout;
    end

    // ---------------- stage 9: raw*SENS/2^21 - OFF ----------------
    logic signed [PROD_W-1:0] n_prod_adj;
    logic signed [DIFF_W-1:0] r_s9_diff;
    logic signed [TOUT_W-1:0] r_s9_tout;

    assign n_prod_adj = w_prod + (w_prod[PROD_W-1] ?
                        PROD_W'((64'd1 << SH_PRES) - 64'd1) : PROD_W'(0));

    always_ff @(posedge i_clk) begin
        r_s9_diff <= DIFF_W'(n_prod_adj >>> SH_PRES) - DIFF_W'(r_s8_off);
        r_s9_tout <= r_s8_tout;
    end

    // ---------------- stage 10: /2^15, result registers ----------------
    logic signed [DIFF_W-1:0] n_diff_adj, n_pres;

    assign n_diff_adj = r_s9_diff + (r_s9_diff[DIFF_W-1] ?
                        DIFF_W'((64'd1 << SH_OUT) - 64'd1) : DIFF_W'(0));
    assign n_pres     = n_diff_adj >>> SH_OUT;

    always_ff @(posedge i_clk) begin
        o_pressure_out    <= n_pres[POUT_W-1:0];
        o_temperature_out <= r_s9_tout;
    end

endmodule

@@ rtl/core/bpc_checker.sv @@
// Port-level checks for baro_pressure_compensation_core, bound to the top level.
// Depends on bpc_pkg for the pipeline latency.
module bpc_checker import bpc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    logic w_take;
    assign w_take = i_start && !o_busy;

    // every taken item comes out after the fixed latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##PIPE_LAT o_done)
        else $error("taken item produced no result");

    // no result without an item taken one latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_take, PIPE_LAT))
        else $error("result without a matching item");

    // reset flushes the pipe
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

endmodule

bind baro_pressure_compensation_core bpc_checker u_bpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done)
);

@@ test/bpc_result_checker.sv @@
// Checker for the barometric compensation core: tracks calibration writes, predicts each result.
// Depends on bpc_pkg; instantiated by tb beside the core.
module bpc_result_checker import bpc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    input  logic                      i_done,
    input  logic signed [POUT_W-1:0]  i_pressure_out,
    input  logic signed [TOUT_W-1:0]  i_temperature_out,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int REPORT_MAX = 50;

    localparam longint TEMP_DIV = longint'(1) << SH_TEMP;
    localparam longint OFF_DIV  = longint'(1) << SH_OFF;
    localparam longint SENS_DIV = longint'(1) << SH_SENS;
    localparam longint T2_DIV   = longint'(1) << SH_T2;
    localparam longint PRES_DIV = longint'(1) << SH_PRES;
    localparam longint OUT_DIV  = longint'(1) << SH_OUT;

    typedef struct packed {
        logic signed [POUT_W-1:0] pressure;
        logic signed [TOUT_W-1:0] temperature;
    } t_reading;

    logic [CAL_W-1:0] cal_word [0:5];
    logic             second_on;
    t_reading         expected_readings [$];
    int               mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic report(input string what, input longint got, input longint want);
        if (mismatch_total < REPORT_MAX)
            $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_total++;
    endtask

    // first-order terms, then the low/very-low temperature correction;
    // SV signed division truncates toward zero like the spec requires
    function automatic t_reading compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                    input logic [RAW_W-1:0] raw_t);
        t_reading res;
        longint d1, dt, temp, off, sens, temp_fin, dev, dev_sq, off2, sens2, vdev, vdev_sq, p;
        d1   = longint'(raw_p);
        dt   = longint'(raw_t) - (longint'(cal_word[REG_REF_TEMP]) << SH_C5);
        temp = longint'(TEMP_REF) + (dt * longint'(cal_word[REG_TEMP_SLOPE])) / TEMP_DIV;
        off  = (longint'(cal_word[REG_OFFSET_BASE]) << SH_C2)
             + (longint'(cal_word[REG_OFFSET_TEMP]) * dt) / OFF_DIV;
        sens = (longint'(cal_word[REG_SENS_BASE]) << SH_C1)
             + (longint'(cal_word[REG_SENS_TEMP]) * dt) / SENS_DIV;
        temp_fin = temp;
        if (second_on && temp < longint'(TEMP_REF)) begin
            dev    = temp - longint'(TEMP_REF);
            dev_sq = dev * dev;
            off2   = 5 * dev_sq / 2;
            sens2  = 5 * dev_sq / 4;
            if (temp < longint'(TEMP_VLOW)) begin
                vdev    = temp - longint'(TEMP_VLOW);
                vdev_sq = vdev * vdev;
                off2    = off2 + 7 * vdev_sq;
                sens2   = sens2 + 11 * vdev_sq / 2;
            end
            off      = off - off2;
            sens     = sens - sens2;
            temp_fin = temp - (dt * dt) / T2_DIV;
        end
        p = (d1 * sens / PRES_DIV - off) / OUT_DIV;
        res.pressure    = p[POUT_W-1:0];
        res.temperature = temp_fin[TOUT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            expected_readings.delete();
            for (int i = 0; i < 6; i++)
                cal_word[i] = '0;
            second_on = 1'b0;
            o_pending <= 0;
        end else begin
            // out-of-range index is dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SECOND_ORDER)
                    second_on = i_cfg_data[0];
                else if (i_cfg_index <= REG_TEMP_SLOPE)
                    cal_word[i_cfg_index] = i_cfg_data;
            end
            if (i_done) begin
                if (expected_readings.size() == 0) begin
                    report("result with no item pending", i_pressure_out, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_pressure_out !== want.pressure)
                        report("pressure_out", i_pressure_out, want.pressure);
                    if (i_temperature_out !== want.temperature)
                        report("temperature_out", i_temperature_out, want.temperature);
                end
            end
            if (i_start && !i_busy)
                expected_readings.push_back(compensate_reading(i_raw_pressure,
                                                               i_raw_temperature));
            o_pending <= expected_readings.size();
        end
    end

endmodule

@@ test/tb.sv @@
// Testbench top for baro_pressure_compensation_core: clock, reset, stimulus and verdict.
// Depends on bpc_pkg, the core and bpc_result_checker.
module tb;
    import bpc_pkg::*;

    // stimulus sizing
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int WATCHDOG_LIMIT = 2000;    // cycles with no handshake of any kind

    // calibration sets
    localparam int CAL_TYPICAL = 0;
    localparam int CAL_MAX     = 1;
    localparam int CAL_ZERO    = 2;
    localparam int CAL_RANDOM  = 3;

    // index with no register behind it; the core must drop the write
    localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    // a realistic factory calibration, word 5 down to word 0
    localparam logic [6*CAL_W-1:0] TYPICAL_CAL = {16'd28312, 16'd33464, 16'd23282,
                                                  16'd23317, 16'd36924, 16'd40127};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [RAW_W-1:0]          raw_pressure = '0;
    logic [RAW_W-1:0]          raw_temperature = '0;
    logic                      done;
    logic signed [POUT_W-1:0]  pressure_out;
    logic signed [TOUT_W-1:0]  temperature_out;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CAL_W-1:0]          cfg_data = '0;

    int mismatches;
    int pending;
    int stall_cycles = 0;

    // stimulus-side copy of the calibration, used to steer raw temperatures
    logic [CAL_W-1:0] cal_word [0:5] = '{default: '0};

    // period 10
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    baro_pressure_compensation_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_raw_pressure    (raw_pressure),
        .i_raw_temperature (raw_temperature),
        .o_done            (done),
        .o_pressure_out    (pressure_out),
        .o_temperature_out (temperature_out),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    bpc_result_checker u_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_raw_pressure    (raw_pressure),
        .i_raw_temperature (raw_temperature),
        .i_done            (done),
        .i_pressure_out    (pressure_out),
        .i_temperature_out (temperature_out),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    // Watchdog: any item, result or register write resets the count.
    // Outputs only change at the rising edge, so sampling here sees pre-edge values.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one item and hold it until taken. Each cycle before it, start
    // stays low with the idle chance, so idle_pct is the share of idle cycles.
    // Busy is read at the falling edge: the core only changes it at rising
    // edges, so that read is the value the next edge will see.
    task automatic send_item(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                             input int idle_pct);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        raw_pressure    <= p;
        raw_temperature <= t;
        do begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    // one register write through the valid/ready channel; valid stays high
    // between back-to-back writes and is dropped by the caller
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Pick a calibration set and write every register. A stray write to the
    // unused index goes first; the enable gets junk in its upper data bits.
    task automatic apply_calibration(input int kind, input logic second);
        for (int i = 0; i < 6; i++) begin
            case (kind)
                CAL_TYPICAL: cal_word[i] = TYPICAL_CAL[i*CAL_W +: CAL_W];
                CAL_MAX:     cal_word[i] = '1;
                CAL_ZERO:    cal_word[i] = '0;
                default:     cal_word[i] = CAL_W'($urandom());
            endcase
        end
        write_reg(CFG_IDX_UNUSED, CAL_W'($urandom()));
        for (int i = REG_SENS_BASE; i <= REG_TEMP_SLOPE; i++)
            write_reg(IDX_W'(i), cal_word[i]);
        write_reg(REG_SECOND_ORDER, {(CAL_W-1)'($urandom()), second});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every expected result. Pending is read at the
    // falling edge so an item taken at the last edge is already counted.
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial begin
        int idle_pct;
        int span;
        int near_ref;
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // calibration still at reset: all words zero
        send_item('0, '0, 0);
        send_item(RAW_MAX, RAW_MAX, 0);
        drain();

        // realistic calibration, second order on: the temperature sweeps
        // from warm through the reference point into the low and very-low bands
        apply_calibration(CAL_TYPICAL, 1'b1);
        send_item(24'd9085466, 24'd8569150, 0);   // above reference, first order only
        send_item(24'd9085466, 24'd8566784, 0);   // dT = 0, TEMP exactly 2000
        send_item(24'd9085466, 24'd8566783, 0);   // dT = -1, TEMP truncates back to 2000
        send_item(24'd9085466, 24'd8000000, 0);   // low band
        send_item(24'd9085466, 24'd7000000, 0);   // very-low band
        send_item('0, '0, 0);                     // most negative dT
        send_item(RAW_MAX, '0, 0);
        send_item('0, RAW_MAX, 0);
        send_item(RAW_MAX, RAW_MAX, 0);
        drain();

        // all words at maximum: largest intermediates, pressure wraps
        apply_calibration(CAL_MAX, 1'b1);
        send_item('0, '0, 0);
        send_item(RAW_MAX, '0, 0);
        send_item('0, RAW_MAX, 0);
        send_item(RAW_MAX, RAW_MAX, 0);
        send_item(RAW_MAX, 24'd8388608, 0);
        drain();

        // same words, first order only
        apply_calibration(CAL_MAX, 1'b0);
        send_item(RAW_MAX, '0, 0);
        send_item(24'h555555, 24'hAAAAAA, 0);
        drain();

        // ---- random ----
        // Sender idling cycles through none / 53% / none / 8% across phases.
        // A quarter of temperatures land near the reference so the threshold
        // crossings at 20.00 and -15.00 degC are hit often.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       apply_calibration(CAL_TYPICAL, 1'b1);
                1:       apply_calibration(CAL_MAX, 1'b1);
                2:       apply_calibration(CAL_ZERO, 1'b1);
                3:       apply_calibration(CAL_TYPICAL, 1'b0);
                default: apply_calibration(CAL_RANDOM, ph[0]);
            endcase
            case (ph % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 53;
                2:       idle_pct = 0;
                default: idle_pct = 8;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(15) == 0)
                    p = $urandom_range(1) ? RAW_MAX : '0;
                else
                    p = RAW_W'($urandom());
                case ($urandom_range(3))
                    1: begin
                        span     = 1 << $urandom_range(4, 21);
                        near_ref = int'({cal_word[REG_REF_TEMP], 8'd0})
                                 + int'($urandom_range(2 * span)) - span;
                        if (near_ref < 0)
                            near_ref = 0;
                        else if (near_ref > int'(RAW_MAX))
                            near_ref = int'(RAW_MAX);
                        t = RAW_W'(near_ref);
                    end
                    2: t = $urandom_range(1) ? RAW_MAX : '0;
                    default: t = RAW_W'($urandom());
                endcase
                send_item(p, t, idle_pct);
            end
            drain();
        end

        // tail longer than the pipeline latency so a stray late result is still caught
        repeat (2 * PIPE_LAT) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
